// ----- rtl/core/msq_pkg.sv -----
// Shared constants, codes and types for the melody note sequencer.
`timescale 1ns / 1ps

package msq_pkg;

  localparam int SONG_BYTES = 1024;
  localparam int SA_W       = $clog2(SONG_BYTES);

  localparam logic [7:0]  END_MARK      = 8'hFF;
  localparam logic [15:0] GAP_MS        = 16'd5;
  localparam logic [15:0] PROGRESS_SPAN = 16'd120;
  localparam logic [15:0] BEAT_RESET    = 16'd125;
  localparam logic [7:0]  PROG_FULL     = 8'd255;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam int DIV_W      = 16;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SOUND = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

endpackage

// ----- rtl/core/msq_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/msq_div.sv -----
// Iterative restoring divider for the progress value, two quotient bits per cycle.
`timescale 1ns / 1ps

module msq_div
  import msq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     div_r, div_nxt;
  logic [DIV_W-1:0]     rem_v, quo_v;
  logic [DIV_W:0]       trial;

  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_v, quo_v[DIV_W-1]};
      if (trial >= {1'b0, div_r}) begin
        rem_v = DIV_W'(trial - {1'b0, div_r});
        quo_v = {quo_v[DIV_W-2:0], 1'b1};
      end else begin
        rem_v = trial[DIV_W-1:0];
        quo_v = {quo_v[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DIV_CYCLES);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      rem_nxt  = rem_v;
      quo_nxt  = quo_v;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/melody_note_sequencer_core.sv -----
// Top level of the melody note sequencer: song store, settle sequencer and outputs.
//
//   channel  ports                                   handshake
//   input    in_op, in_address, in_data              start & !busy
//   result   out_tone_on .. out_phase                out_valid, one cycle
//   config   cfg_data (beat_ms)                      cfg_valid & cfg_ready
//
// A word with no note read goes from acceptance through a settle pass to its strobe;
// the end marker adds a store read and a second pass; a note load takes four song store
// reads on the single read port, then the divider's 8 iterations if the divisor is nonzero.
// busy is low only while idle; the next word may be accepted in the strobe cycle.
// Reset is synchronous: state clears, playback paused, beat_ms back to 125.
// The result strobe cannot be stalled; the store itself is not cleared by reset.
`timescale 1ns / 1ps

module melody_note_sequencer_core
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [9:0]  in_address,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  output logic        out_tone_on,
  output logic [7:0]  out_note,
  output logic [7:0]  out_progress,
  output logic        out_finished,
  output logic        out_paused,
  output logic [1:0]  out_phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_RD_NOTE,
    S_RD_LEN,
    S_RD_HI,
    S_RD_LO,
    S_DIV
  } state_t;

  state_t      state_r, state_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [15:0] cd_r, cd_nxt;
  phase_t      phase_r, phase_nxt;
  logic        done_flag_r, done_flag_nxt;
  logic        pause_r, pause_nxt;
  logic [7:0]  prog_r, prog_nxt;
  logic        tone_on_r, tone_on_nxt;
  logic [7:0]  tone_note_r, tone_note_nxt;
  logic [15:0] beat_r, beat_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [10:0] ptr_r, ptr_nxt;
  logic        beyond_r, beyond_nxt;
  logic [7:0]  note_r, note_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic [7:0]  cnt_hi_r, cnt_hi_nxt;

  logic [8:0]  pos_e;
  logic [15:0] cd_e;
  phase_t      phase_e;
  logic        done_e;
  logic        fire;
  logic [9:0]  pos_inc;
  logic [10:0] ptr_e;
  logic [10:0] ptr_len;
  logic [8:0]  pos_next;
  logic [7:0]  note_v;
  logic [7:0]  len_v;
  logic [23:0] prod;
  logic [15:0] cnt_v;

  logic            ram_wr_en;
  logic            ram_rd_en;
  logic [SA_W-1:0] ram_rd_addr;
  logic [7:0]      ram_rd_data;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic             div_done;
  logic [DIV_W-1:0] div_quotient;

  assign ram_wr_en = start && !busy && (in_op == OP_LOAD) && (32'(in_address) < SONG_BYTES);

  msq_ram #(
    .WIDTH (8),
    .DEPTH (SONG_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (SA_W'(in_address)),
    .wr_data (in_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  msq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_v),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    if (prog_r == '0) begin
      pos_e   = '0;
      cd_e    = '0;
      phase_e = PH_IDLE;
      done_e  = 1'b0;
    end else begin
      pos_e   = pos_r;
      cd_e    = cd_r;
      phase_e = phase_r;
      done_e  = done_flag_r;
    end
    fire     = !done_e && !pause_r && (cd_e == '0);
    pos_inc  = {1'b0, pos_e} + 10'd1;
    ptr_e    = {pos_inc, 1'b0};
    ptr_len  = ptr_r + 11'd1;
    pos_next = pos_r + 9'd1;
    note_v   = beyond_r ? END_MARK : ram_rd_data;
    len_v    = beyond_r ? 8'd0 : ram_rd_data;
    prod     = {16'd0, len_v} * {8'd0, beat_r};
    cnt_v    = {cnt_hi_r, ram_rd_data};
    div_dividend = DIV_W'({7'd0, pos_next}) * DIV_W'(PROGRESS_SPAN);
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cd_nxt        = cd_r;
    phase_nxt     = phase_r;
    done_flag_nxt = done_flag_r;
    pause_nxt     = pause_r;
    prog_nxt      = prog_r;
    tone_on_nxt   = tone_on_r;
    tone_note_nxt = tone_note_r;
    beat_nxt      = beat_r;
    out_valid_nxt = 1'b0;
    ptr_nxt       = ptr_r;
    beyond_nxt    = beyond_r;
    note_nxt      = note_r;
    dur_nxt       = dur_r;
    cnt_hi_nxt    = cnt_hi_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    div_start     = 1'b0;

    if (cfg_valid) begin
      beat_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_op)
            OP_START: begin
              prog_nxt  = '0;
              pause_nxt = 1'b0;
            end
            OP_PAUSE:  pause_nxt = 1'b1;
            OP_RESUME: pause_nxt = 1'b0;
            OP_TICK: begin
              if (cd_r != '0) begin
                cd_nxt = cd_r - 16'd1;
              end
            end
            default: ;
          endcase
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        pos_nxt       = pos_e;
        cd_nxt        = cd_e;
        phase_nxt     = phase_e;
        done_flag_nxt = done_e;
        if (fire && (phase_e == PH_SOUND)) begin
          tone_on_nxt   = 1'b0;
          tone_note_nxt = '0;
          cd_nxt        = GAP_MS;
          phase_nxt     = PH_GAP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (fire) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = SA_W'(ptr_e);
          ptr_nxt     = ptr_e;
          beyond_nxt  = (32'(ptr_e) >= SONG_BYTES);
          state_nxt   = S_RD_NOTE;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RD_NOTE: begin
        if (note_v == END_MARK) begin
          done_flag_nxt = 1'b1;
          pause_nxt     = 1'b1;
          phase_nxt     = PH_IDLE;
          tone_on_nxt   = 1'b0;
          tone_note_nxt = '0;
          state_nxt     = S_PASS;
        end else begin
          note_nxt    = note_v;
          ram_rd_en   = 1'b1;
          ram_rd_addr = SA_W'(ptr_len);
          beyond_nxt  = (32'(ptr_len) >= SONG_BYTES);
          state_nxt   = S_RD_LEN;
        end
      end
      S_RD_LEN: begin
        dur_nxt     = (prod[23:16] != '0) ? 16'hFFFF : prod[15:0];
        ram_rd_en   = 1'b1;
        ram_rd_addr = SA_W'(0);
        state_nxt   = S_RD_HI;
      end
      S_RD_HI: begin
        cnt_hi_nxt  = ram_rd_data;
        ram_rd_en   = 1'b1;
        ram_rd_addr = SA_W'(1);
        state_nxt   = S_RD_LO;
      end
      S_RD_LO: begin
        tone_on_nxt   = (note_r != '0);
        tone_note_nxt = note_r;
        cd_nxt        = dur_r;
        phase_nxt     = PH_SOUND;
        pos_nxt       = pos_next;
        if (cnt_v == '0) begin
          prog_nxt  = PROG_FULL;
          state_nxt = S_PASS;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          prog_nxt  = (div_quotient >= DIV_W'(PROG_FULL)) ? PROG_FULL
                                                          : div_quotient[7:0] + 8'd1;
          state_nxt = S_PASS;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cd_r        <= '0;
      phase_r     <= PH_IDLE;
      done_flag_r <= 1'b0;
      pause_r     <= 1'b1;
      prog_r      <= '0;
      tone_on_r   <= 1'b0;
      tone_note_r <= '0;
      beat_r      <= BEAT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cd_r        <= cd_nxt;
      phase_r     <= phase_nxt;
      done_flag_r <= done_flag_nxt;
      pause_r     <= pause_nxt;
      prog_r      <= prog_nxt;
      tone_on_r   <= tone_on_nxt;
      tone_note_r <= tone_note_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r    <= ptr_nxt;
    beyond_r <= beyond_nxt;
    note_r   <= note_nxt;
    dur_r    <= dur_nxt;
    cnt_hi_r <= cnt_hi_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_tone_on  = tone_on_r;
  assign out_note     = tone_note_r;
  assign out_progress = prog_r;
  assign out_finished = done_flag_r;
  assign out_paused   = pause_r;
  assign out_phase    = phase_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start settling");

  a_tone_note: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tone_on |-> (out_note == 8'd0))
    else $error("note nonzero while tone is off");

endmodule
